// ----- design/csq_pkg.sv -----
package csq_pkg;

  // Largest frame dimension the counters and the address path are sized for.
  localparam int MAX_DIM = 2048;

  // Counter width holds 0 .. MAX_DIM-1; dimension width holds 1 .. MAX_DIM.
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = CNT_W + 1;

  // Fixed field widths.
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int ROT_W     = 2;
  localparam int PIX_W     = 16;
  localparam int ADDR_W    = 22;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 2'd2;

  // Rotation codes.
  localparam logic [ROT_W-1:0] ROT_NONE  = 2'd0;
  localparam logic [ROT_W-1:0] ROT_CCW90 = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180   = 2'd2;
  localparam logic [ROT_W-1:0] ROT_CW90  = 2'd3;

  // Frame geometry derived from the configuration registers.
  typedef struct packed {
    logic [DIM_W-1:0] w;     // clamped frame width
    logic [DIM_W-1:0] h;     // clamped frame height
    logic [DIM_W-1:0] n;     // square side
    logic [CNT_W-1:0] xs;    // first column of the square
    logic [CNT_W-1:0] ys;    // first row of the square
    logic [ROT_W-1:0] rot;   // rotation code
  } geom_t;

  // One pixel with its frame position, between the input stage and the address path.
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
  } pos_t;

endpackage

// ----- design/csq_cfg_regs.sv -----
module csq_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wen,
  input  logic [csq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csq_pkg::CFG_W-1:0]        cfg_wdata,
  output csq_pkg::geom_t                   geom
);
  import csq_pkg::*;

  localparam int CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;

  logic [CFG_W-1:0] width_r,  width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [ROT_W-1:0] rot_r,    rot_nxt;

  logic [DIM_W-1:0] w_c, h_c, lo, hi, diff;

  // A zero dimension acts as one, an oversized one as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    if (ext == '0) begin
      return DIM_W'(1);
    end else if (ext > CMP_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(ext);
    end
  endfunction

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    rot_nxt    = rot_r;
    if (cfg_wen) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = cfg_wdata;
        CFG_FRAME_HEIGHT: height_nxt = cfg_wdata;
        CFG_ROTATION:     rot_nxt    = cfg_wdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(640);
      height_r <= CFG_W'(480);
      rot_r    <= ROT_NONE;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      rot_r    <= rot_nxt;
    end
  end

  always_comb begin
    w_c  = clamp_dim(width_r);
    h_c  = clamp_dim(height_r);
    lo   = (w_c > h_c) ? h_c : w_c;
    hi   = (w_c > h_c) ? w_c : h_c;
    diff = hi - lo;
    geom.w   = w_c;
    geom.h   = h_c;
    geom.n   = lo;
    geom.rot = rot_r;
    // The square is centered along the longer axis, offset rounded down.
    geom.xs  = (w_c > h_c) ? diff[DIM_W-1:1] : '0;
    geom.ys  = (w_c > h_c) ? '0 : diff[DIM_W-1:1];
  end

endmodule

// ----- design/csq_position.sv -----
module csq_position (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csq_pkg::geom_t                geom,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csq_pkg::PIX_W-1:0]     in_pixel,
  input  logic                          in_sof,
  output csq_pkg::pos_t                 s1,
  input  logic                          s1_ready
);
  import csq_pkg::*;

  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0] col_cur, row_cur;
  logic [DIM_W-1:0] col_inc, row_inc;
  pos_t             s1_r, s1_nxt;
  logic             load, acc;

  assign load     = !s1_r.valid || s1_ready;
  assign in_ready = load;
  assign acc      = in_valid && load;

  always_comb begin
    col_cur = in_sof ? '0 : col_cnt_r;
    row_cur = in_sof ? '0 : row_cnt_r;
    col_inc = DIM_W'(col_cur) + DIM_W'(1);
    row_inc = DIM_W'(row_cur) + DIM_W'(1);
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (acc) begin
      if (col_inc >= geom.w) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (row_inc >= geom.h) ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_cnt_nxt = col_inc[CNT_W-1:0];
        // A row left behind by a smaller height wraps here.
        row_cnt_nxt = (DIM_W'(row_cur) >= geom.h) ? '0 : row_cur;
      end
    end
  end

  always_comb begin
    s1_nxt = s1_r;
    if (load) begin
      s1_nxt.valid = in_valid;
      s1_nxt.pixel = in_pixel;
      s1_nxt.col   = col_cur;
      s1_nxt.row   = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_r.valid <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.pixel <= s1_nxt.pixel;
    s1_r.col   <= s1_nxt.col;
    s1_r.row   <= s1_nxt.row;
  end

  assign s1 = s1_r;

  // A word flagged as start of frame always enters at the frame origin.
  a_sof_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_sof) |=> (s1_r.col == '0 && s1_r.row == '0))
    else $error("start of frame word not placed at column 0, row 0");

  // Backpressure only ever comes from a held word in the input stage.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_r.valid)
    else $error("input stalled with an empty input stage");

endmodule

// ----- design/csq_addr.sv -----
module csq_addr (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csq_pkg::geom_t                geom,
  input  csq_pkg::pos_t                 s1,
  output logic                          s1_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csq_pkg::ADDR_W-1:0]    out_addr,
  output logic [csq_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_done
);
  import csq_pkg::*;

  localparam int PROD_W = CNT_W + DIM_W;

  // Operand stage.
  logic             s2_v_r,    s2_v_nxt;
  logic [CNT_W-1:0] s2_a_r,    s2_a_nxt;
  logic [CNT_W-1:0] s2_c_r,    s2_c_nxt;
  logic             s2_done_r, s2_done_nxt;
  logic [PIX_W-1:0] s2_pix_r,  s2_pix_nxt;
  // Result register.
  logic              out_v_r,    out_v_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [PIX_W-1:0]  out_pix_r,  out_pix_nxt;
  logic              out_done_r, out_done_nxt;

  logic             s2_ready, s3_ready, in_square;
  logic [CNT_W-1:0] x, y, nm1;
  logic [PROD_W-1:0] prod, sum;

  assign s3_ready = !out_v_r || out_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = s2_ready;

  always_comb begin
    x         = s1.col - geom.xs;
    y         = s1.row - geom.ys;
    nm1       = CNT_W'(geom.n - DIM_W'(1));
    in_square = (s1.col >= geom.xs) && (DIM_W'(x) < geom.n) &&
                (s1.row >= geom.ys) && (DIM_W'(y) < geom.n);

    s2_v_nxt    = s2_v_r;
    s2_a_nxt    = s2_a_r;
    s2_c_nxt    = s2_c_r;
    s2_done_nxt = s2_done_r;
    s2_pix_nxt  = s2_pix_r;
    if (s2_ready) begin
      // Pixels outside the square are dropped here.
      s2_v_nxt    = s1.valid && in_square;
      s2_pix_nxt  = s1.pixel;
      s2_done_nxt = (x == nm1) && (y == nm1);
      // Address is a * N + c for every rotation.
      case (geom.rot)
        ROT_NONE: begin
          s2_a_nxt = y;
          s2_c_nxt = x;
        end
        ROT_CCW90: begin
          s2_a_nxt = nm1 - x;
          s2_c_nxt = y;
        end
        ROT_180: begin
          s2_a_nxt = nm1 - y;
          s2_c_nxt = nm1 - x;
        end
        default: begin
          s2_a_nxt = x;
          s2_c_nxt = nm1 - y;
        end
      endcase
    end
  end

  always_comb begin
    prod = PROD_W'(s2_a_r) * PROD_W'(geom.n);
    sum  = prod + PROD_W'(s2_c_r);

    out_v_nxt    = out_v_r;
    out_addr_nxt = out_addr_r;
    out_pix_nxt  = out_pix_r;
    out_done_nxt = out_done_r;
    if (s3_ready) begin
      out_v_nxt    = s2_v_r;
      out_addr_nxt = ADDR_W'(sum);
      out_pix_nxt  = s2_pix_r;
      out_done_nxt = s2_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_a_r     <= s2_a_nxt;
    s2_c_r     <= s2_c_nxt;
    s2_done_r  <= s2_done_nxt;
    s2_pix_r   <= s2_pix_nxt;
    out_addr_r <= out_addr_nxt;
    out_pix_r  <= out_pix_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid = out_v_r;
  assign out_addr  = out_addr_r;
  assign out_pixel = out_pix_r;
  assign out_done  = out_done_r;

  // A word in the operand stage moves into the result register when it is free.
  a_s2_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s3_ready) |=> out_v_r)
    else $error("operand stage word lost on its way to the result register");

  // Reset empties both stages.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !s2_v_r))
    else $error("pipeline not empty after reset");

  // A pixel outside the square never enters the operand stage.
  a_drop_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_ready && s1.valid && !in_square) |=> !s2_v_r)
    else $error("pixel outside the square kept");

endmodule

// ----- design/center_square_crop_rotate.sv -----
// Center square crop and rotate for an RGB565 camera stream. Pixels arrive in
// raster order as input words, with in_tuser high on the first pixel of a frame
// (that pixel is taken as column 0, row 0; a frame without the marker simply
// wraps after its last row). The square side N is the smaller of the clamped
// frame width and height (0 acts as 1, anything above 2048 acts as 2048), and
// the square is centered along the longer axis with the offset rounded down.
// Every pixel inside the square leaves as one output word carrying the pixel
// unchanged and its linear address in the N by N image after the selected
// rotation; pixels outside the square produce nothing. out_tlast flags the
// last pixel of the square. The block takes one word per clock cycle while
// out_tready keeps up, under any pattern of input gaps; back-pressure from
// out_tready can stall the input. A pixel passes the input register, the
// operand register that follows the square test and rotation select, and
// the result register behind the single multiply-add of the address. There is
// no clearing pass after reset. Configuration registers must only be written
// while no words are in flight; they act on the next pixel.
module center_square_crop_rotate (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port: 0 frame_width, 1 frame_height, 2 rotation.
  input  logic                          cfg_wen,
  input  logic [csq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csq_pkg::CFG_W-1:0]     cfg_wdata,
  // Input stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] pixel_in
  input  logic                          in_tuser,   // [0] start_of_frame
  // Output stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // [21:0] dest_address, [37:22] pixel_out
  output logic                          out_tlast   // square_done
);
  import csq_pkg::*;

  geom_t             geom;
  pos_t              s1;
  logic              s1_ready;
  logic [ADDR_W-1:0] addr;
  logic [PIX_W-1:0]  pixel;

  // Configuration registers and the frame geometry derived from them.
  csq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  // Column and row counters plus the input register.
  csq_position u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pixel (in_tdata),
    .in_sof   (in_tuser),
    .s1       (s1),
    .s1_ready (s1_ready)
  );

  // Square test, rotation and address arithmetic up to the result register.
  csq_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .s1        (s1),
    .s1_ready  (s1_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (addr),
    .out_pixel (pixel),
    .out_done  (out_tlast)
  );

  assign out_tdata = {2'b00, pixel, addr};

endmodule

// ----- tb/square_addr_check.sv -----
`timescale 1ns / 1ps

module square_addr_check
  import csq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,   // [15:0] pixel_in
  input  logic                 in_tuser,   // [0] start_of_frame
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [39:0]          out_tdata,  // [21:0] dest_address, [37:22] pixel_out
  input  logic                 out_tlast,  // square_done
  output int                   mismatches,
  output int                   outstanding
);

  localparam int REPORT_CAP = 30;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic              last;
  } placed_pixel_t;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [ROT_W-1:0] rot_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  placed_pixel_t    awaited[$];

  function automatic int unsigned effective_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Advances the frame position past one pixel. Returns 1 and the placed word
  // when the pixel falls inside the centered square.
  function automatic bit place_pixel(input logic [PIX_W-1:0] pix, input logic sof,
                                     output placed_pixel_t word);
    int unsigned w, h, n, xs, ys, col, row, x, y, addr;
    bit hit;
    w = effective_dim(width_reg);
    h = effective_dim(height_reg);
    if (w > h) begin
      n = h;
      xs = (w - h) / 2;
      ys = 0;
    end else begin
      n = w;
      xs = 0;
      ys = (h - w) / 2;
    end
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos;
    row = row_pos;
    hit = (col >= xs) && (col - xs < n) && (row >= ys) && (row - ys < n);
    word = '0;
    if (hit) begin
      x = col - xs;
      y = row - ys;
      case (rot_reg)
        ROT_NONE:  addr = y * n + x;
        ROT_CCW90: addr = (n - 1 - x) * n + y;
        ROT_180:   addr = (n - 1 - y) * n + (n - 1 - x);
        ROT_CW90:  addr = x * n + (n - 1 - y);
      endcase
      word.addr  = ADDR_W'(addr);
      word.pixel = pix;
      word.last  = (x == n - 1) && (y == n - 1);
    end
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
    if (row_pos >= h) row_pos = 0;
    return hit;
  endfunction

  always @(posedge clk) begin
    placed_pixel_t got, want, fresh;
    bit bad;
    if (!rst_n) begin
      width_reg  = 12'd640;
      height_reg = 12'd480;
      rot_reg    = ROT_NONE;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
      awaited.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_reg = cfg_wdata;
          CFG_FRAME_HEIGHT: height_reg = cfg_wdata;
          CFG_ROTATION:     rot_reg = cfg_wdata[ROT_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.addr  = out_tdata[ADDR_W-1:0];
        got.pixel = out_tdata[ADDR_W +: PIX_W];
        got.last  = out_tlast;
        if (awaited.size() == 0) begin
          if (mismatches < REPORT_CAP)
            $error("unexpected word: dest_address %0d pixel_out %h", got.addr, got.pixel);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          bad = 1'b0;
          if (got.addr !== want.addr) begin
            bad = 1'b1;
            if (mismatches < REPORT_CAP)
              $error("dest_address: expected %0d, got %0d", want.addr, got.addr);
          end
          if (got.pixel !== want.pixel) begin
            bad = 1'b1;
            if (mismatches < REPORT_CAP)
              $error("pixel_out: expected %h, got %h", want.pixel, got.pixel);
          end
          if (got.last !== want.last) begin
            bad = 1'b1;
            if (mismatches < REPORT_CAP)
              $error("square_done: expected %0d, got %0d", want.last, got.last);
          end
          if (bad) mismatches++;
        end
      end
      if (in_tvalid && in_tready) begin
        if (place_pixel(in_tdata, in_tuser, fresh)) awaited.push_back(fresh);
      end
    end
    outstanding <= awaited.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import csq_pkg::*;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_PIXELS     = 1200;
  localparam int STALL_LIMIT       = 2000;
  localparam int BACKPRESSURE_HOLD = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic                 out_tlast;

  int mismatches;
  int outstanding;
  int pixels_sent = 0;
  int idle_cycles = 0;
  // When set, the sender offers words back to back for the whole phase.
  bit gapless = 1'b0;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit hold_request = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  center_square_crop_rotate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  square_addr_check crop_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Gap before the next input word. Most gaps are zero or short; a few are
  // long enough to let the pipeline run completely dry.
  function automatic int pick_gap();
    int r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one pixel and returns at the edge where it is accepted. Valid is
  // left high so that a back-to-back word does not drop it for a step.
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= sof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Streams random pixels. A start marker goes on the first word when asked
  // and then at every frame boundary; noise flips the marker at random.
  task automatic stream_pixels(input int count, input int frame_len, input bit lead_sof,
                               input int noise_pct);
    logic sof;
    for (int i = 0; i < count; i++) begin
      sof = (i == 0) ? lead_sof : (frame_len > 0 && i % frame_len == 0);
      if ($urandom_range(0, 99) < noise_pct) sof = ~sof;
      push_pixel(PIX_W'($urandom), sof);
    end
  endtask

  // Drops valid and waits until every expected word has come out. Pixels
  // outside the square produce nothing, so an extra wait then covers any that
  // are still in the three-stage pipeline.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges, with enable held high
  // throughout. The rotation word carries random upper bits, which the block
  // must ignore. Optionally pokes the unused index with junk.
  task automatic program_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                               input logic [ROT_W-1:0] rot, input bit spare);
    logic [CFG_W-1:0] rot_word;
    rot_word = CFG_W'($urandom);
    rot_word[ROT_W-1:0] = rot;
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_ROTATION;
    cfg_wdata <= rot_word;
    @(posedge clk);
    if (spare) begin
      cfg_index <= CFG_SPARE;
      cfg_wdata <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
  endtask

  // Receiver: bursts of ready with short or long gaps, and some long bursts
  // with no idling at all. A hold request cuts the burst short and keeps
  // ready low long enough for the block to fill and stall its input.
  initial begin : receiver
    int burst;
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (BACKPRESSURE_HOLD) @(posedge clk);
      end
      out_tready <= 1'b1;
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 16);
      repeat (burst) if (!hold_request) @(posedge clk);
      if (!hold_request) begin
        gap = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 3) : $urandom_range(15, 50);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // The run is stuck if neither side moves a word for this long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** center_square_crop_rotate: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int  target;
    int  kind;
    int  w;
    int  h;
    int  frame_len;
    int  count;
    int  noise;
    bit  lead;
    bit  pressure_done;
    pressure_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry is 640x480, so the first columns of row 0 lie left of
    // the square and give nothing. Extreme pixel values go through here.
    push_pixel(16'h0000, 1'b1);
    push_pixel(16'hFFFF, 1'b0);
    settle();

    // Tiny frames, one per rotation other than the clockwise quarter turn.
    program_frame(12'd2, 12'd2, ROT_NONE, 1'b1);
    stream_pixels(4, 4, 1'b1, 0);
    settle();
    program_frame(12'd3, 12'd2, ROT_CCW90, 1'b0);
    stream_pixels(6, 6, 1'b1, 0);
    settle();
    program_frame(12'd2, 12'd4, ROT_180, 1'b0);
    stream_pixels(8, 8, 1'b1, 0);
    settle();

    // A zero width acts as one: a 1x1 square. The second word has no start
    // marker and must wrap to a new frame on its own.
    program_frame(12'd0, 12'd1, ROT_CW90, 1'b0);
    stream_pixels(2, 0, 1'b1, 0);
    settle();

    // Oversized width clamps to the full 2048 square; the addresses of a
    // quarter turn land near the top of the address range.
    program_frame(12'd4095, 12'd2048, ROT_CCW90, 1'b0);
    stream_pixels(3, 0, 1'b1, 0);
    settle();

    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      gapless = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 99);
      noise = 0;
      lead = 1'b1;
      if (!pressure_done && pixels_sent > 400) begin
        // Every pixel of an 8x8 frame is in the square, so output words
        // pile up while the receiver holds off.
        pressure_done = 1'b1;
        gapless = 1'b1;
        w = 8;
        h = 8;
        frame_len = 64;
        count = 256;
        hold_request = 1'b1;
      end else if (kind < 65) begin
        // Whole small frames. Without a leading marker the counters carry
        // over from the previous geometry and may first have to wrap.
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        frame_len = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
        count = frame_len * $urandom_range(1, 3);
        lead = ($urandom_range(0, 3) != 0);
      end else if (kind < 80) begin
        // Broken frames: start markers in random places.
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
        frame_len = w * h;
        count = $urandom_range(10, 40);
        lead = ($urandom_range(0, 1) != 0);
        noise = 12;
      end else if (kind < 94) begin
        // Medium frames, only partly sent.
        w = $urandom_range(16, 48);
        h = $urandom_range(16, 48);
        frame_len = w * h;
        count = $urandom_range(30, 90);
      end else begin
        // Large and oversized frames: a handful of pixels from row 0.
        w = $urandom_range(2048, 4095);
        h = ($urandom_range(0, 2) == 0) ? $urandom_range(1500, 2047)
                                        : $urandom_range(2048, 4095);
        if ($urandom_range(0, 1)) begin
          frame_len = w;
          w = h;
          h = frame_len;
        end
        frame_len = 0;
        count = $urandom_range(8, 20);
      end
      program_frame(CFG_W'(w), CFG_W'(h), ROT_W'($urandom_range(0, 3)),
                    $urandom_range(0, 7) == 0);
      stream_pixels(count, frame_len, lead, noise);
      settle();
    end
    gapless = 1'b0;

    settle();
    repeat (12) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** center_square_crop_rotate: PASSED **");
    end else begin
      $display("** center_square_crop_rotate: FAILED **");
    end
    $finish;
  end

endmodule
